// ===== sv/stochastic_sigmoid_neuron_core_assert.svh =====
// Assertion macros used by the checker of the stochastic sigmoid neuron core.
`ifndef STOCHASTIC_SIGMOID_NEURON_CORE_ASSERT_SVH
`define STOCHASTIC_SIGMOID_NEURON_CORE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define SSN_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ssn assertion failed");

// Check a consequent in the cycle after its antecedent.
`define SSN_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ssn assertion failed");

`endif

// ===== sv/ssn_pkg.sv =====
// Shared types, constants and the sigmoid table of the stochastic sigmoid neuron.
package ssn_pkg;

   localparam int WEIGHT_W    = 16;
   localparam int PARENT_W    = 16;
   localparam int RANDOM_W    = 16;
   localparam int PROB_W      = 16;
   localparam int PROD_W      = 33;
   localparam int SUM_W       = 40;
   localparam int SUM_SHIFT   = 23;
   localparam int IDX_W       = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [PROB_W-1:0] HIGH_THRESHOLD_RESET = 16'd58982;
   localparam logic [PROB_W-1:0] LOW_THRESHOLD_RESET  = 16'd6554;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // e^-1/16 in Q32 and 1.0 in Q30
   localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;
   localparam logic [63:0] ONE_Q30      = 64'd1 << 30;

   // Register map, selected by byte address bit 2
   typedef enum logic [0:0] {
      CSR_HIGH_THRESHOLD = 1'b0,
      CSR_LOW_THRESHOLD  = 1'b1
   } csr_index_type;

   // One accumulated sum that reached the end of its synapse set
   typedef struct packed {
      logic                    valid;
      logic signed [SUM_W-1:0] sum;
      logic [RANDOM_W-1:0]     random_sample;
   } sum_beat_type;

   typedef logic [TABLE_DEPTH-1:0][PROB_W-1:0] sig_table_type;

   // round(65536 / (1 + e^-k/16)), exponent built by repeated rounded steps
   function automatic logic [PROB_W:0] sig_positive(input int unsigned k);
      logic [63:0] v;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] rem;
      logic [47:0] quo;
      v = ONE_Q30;
      for (int i = 0; i < 128; i++) begin
         if (i < k) begin
            v = (v * EXP_STEP_Q32 + 64'h0000_0000_8000_0000) >> 32;
         end
      end
      den = ONE_Q30 + v;
      num = (64'd1 << 46) + (den >> 1);
      rem = 64'd0;
      quo = 48'd0;
      // restoring division, one quotient bit a step
      for (int b = 47; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo[PROB_W:0];
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type t;
      logic [PROB_W:0] p;
      for (int idx = 0; idx < TABLE_DEPTH; idx++) begin
         if (idx >= 128) begin
            p = sig_positive(idx - 128);
            if (p > 17'd65535) begin
               p = 17'd65535;
            end
         end else begin
            p = 17'd65536 - sig_positive(128 - idx);
         end
         t[idx] = p[PROB_W-1:0];
      end
      return t;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

// ===== sv/ssn_mac.sv =====
// Synapse multiply stage and saturating accumulator of the neuron.
module ssn_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                in_valid,
   input  logic signed [ssn_pkg::WEIGHT_W-1:0] weight,
   input  logic [ssn_pkg::PARENT_W-1:0]        parent_output,
   input  logic [ssn_pkg::RANDOM_W-1:0]        random_sample,
   input  logic                                last,
   output ssn_pkg::sum_beat_type               sum_beat
);
   import ssn_pkg::*;

   logic signed [PROD_W-1:0] weight_ext;
   logic signed [PROD_W-1:0] parent_ext;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_valid_ff;
   logic                     prod_last_ff;
   logic [RANDOM_W-1:0]      prod_random_ff;
   logic signed [SUM_W-1:0]  acc_ff;
   logic signed [SUM_W:0]    acc_wide;
   logic signed [SUM_W-1:0]  acc_sat;
   logic                     sum_valid_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [RANDOM_W-1:0]      sum_random_ff;

   // Form the exact product of weight and parent output
   always_comb begin
      weight_ext = {{(PROD_W-WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
      parent_ext = {{(PROD_W-PARENT_W){1'b0}}, parent_output};
      prod_in    = weight_ext * parent_ext;
   end

   // Add the product into the sum and clamp at the signed limits
   always_comb begin
      acc_wide = {acc_ff[SUM_W-1], acc_ff}
               + {{(SUM_W+1-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
         acc_sat = acc_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         acc_sat = acc_wide[SUM_W-1:0];
      end
   end

   // Advance the product stage and the accumulator together
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
         sum_valid_ff  <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= in_valid;
         sum_valid_ff  <= prod_valid_ff && prod_last_ff;
         if (prod_valid_ff) begin
            acc_ff <= prod_last_ff ? '0 : acc_sat;
         end
      end
   end

   // Hold payload without reset
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff        <= prod_in;
         prod_last_ff   <= last;
         prod_random_ff <= random_sample;
         sum_ff         <= acc_sat;
         sum_random_ff  <= prod_random_ff;
      end
   end

   assign sum_beat = '{valid: sum_valid_ff, sum: sum_ff, random_sample: sum_random_ff};

endmodule

// ===== sv/ssn_sigmoid.sv =====
// Sigmoid table lookup and firing decision for one finished sum.
module ssn_sigmoid (
   input  logic signed [ssn_pkg::SUM_W-1:0] sum,
   input  logic [ssn_pkg::RANDOM_W-1:0]     random_sample,
   input  logic [ssn_pkg::PROB_W-1:0]       high_threshold,
   input  logic [ssn_pkg::PROB_W-1:0]       low_threshold,
   output logic                             fire,
   output logic [ssn_pkg::PROB_W-1:0]       probability
);
   import ssn_pkg::*;

   logic [SUM_W-SUM_SHIFT-1:0] step;
   logic                       below_range;
   logic                       above_range;
   logic [IDX_W-1:0]           idx;

   // Floor the sum to steps of 1/16 and clamp into the table range
   always_comb begin
      step        = sum[SUM_W-1:SUM_SHIFT];
      below_range = step[SUM_W-SUM_SHIFT-1] && !(&step[SUM_W-SUM_SHIFT-2:IDX_W-1]);
      above_range = !step[SUM_W-SUM_SHIFT-1] && (|step[SUM_W-SUM_SHIFT-2:IDX_W-1]);
      if (below_range) begin
         idx = '0;
      end else if (above_range) begin
         idx = '1;
      end else begin
         idx = {~step[IDX_W-1], step[IDX_W-2:0]};
      end
      probability = SIG_TABLE[idx];
   end

   // Decide: high threshold first, then low, then the random draw
   always_comb begin
      if (probability > high_threshold) begin
         fire = 1'b1;
      end else if (probability < low_threshold) begin
         fire = 1'b0;
      end else begin
         fire = (random_sample <= probability);
      end
   end

endmodule

// ===== sv/stochastic_sigmoid_neuron_core.sv =====
// Stochastic binary neuron core: one synapse per beat, one fire decision per set.
// Each accepted beat carries one synapse; the core takes one beat per clock cycle
// for as long as the result side keeps up. A result appears on rsp_ only for a beat
// marked last: the beat lands in the input register, passes the product register
// and the accumulator and sum register, and the sigmoid lookup feeds the result
// register. The saturating accumulator sets the rate of one beat per cycle. A
// stalled result freezes the whole pipeline, and the next input beat is taken again
// in the cycle the result is taken. Thresholds are written through the APB-style
// port (high at 0x0, low at 0x4); the user must write them only while no set is in
// flight, and the core does not enforce this.
module stochastic_sigmoid_neuron_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // synapse beats
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [ssn_pkg::WEIGHT_W-1:0]   req_weight,
   input  logic [ssn_pkg::PARENT_W-1:0]          req_parent_output,
   input  logic [ssn_pkg::RANDOM_W-1:0]          req_random_sample,
   input  logic                                  req_last,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_fire,
   output logic [ssn_pkg::PROB_W-1:0]            rsp_probability,
   // configuration
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [ssn_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [ssn_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [ssn_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);
   import ssn_pkg::*;

   logic                    advance;
   logic                    csr_write;
   csr_index_type           csr_index;
   logic [PROB_W-1:0]       high_threshold_ff;
   logic [PROB_W-1:0]       low_threshold_ff;
   logic [PROB_W-1:0]       csr_read_value;

   logic                    in_valid_ff;
   logic signed [WEIGHT_W-1:0] in_weight_ff;
   logic [PARENT_W-1:0]     in_parent_ff;
   logic [RANDOM_W-1:0]     in_random_ff;
   logic                    in_last_ff;

   sum_beat_type            sum_beat;
   logic                    fire_in;
   logic [PROB_W-1:0]       probability_in;

   logic                    rsp_valid_ff;
   logic                    rsp_fire_ff;
   logic [PROB_W-1:0]       rsp_probability_ff;

   // Move the pipeline unless a finished result is waiting
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Decode register writes and reads
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[2]);

   always_comb begin
      unique case (csr_index)
         CSR_HIGH_THRESHOLD: csr_read_value = high_threshold_ff;
         CSR_LOW_THRESHOLD:  csr_read_value = low_threshold_ff;
         default:            csr_read_value = '0;
      endcase
      prdata = {{(CSR_DATA_W-PROB_W){1'b0}}, csr_read_value};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_threshold_ff <= HIGH_THRESHOLD_RESET;
         low_threshold_ff  <= LOW_THRESHOLD_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_HIGH_THRESHOLD: high_threshold_ff <= pwdata[PROB_W-1:0];
            CSR_LOW_THRESHOLD:  low_threshold_ff  <= pwdata[PROB_W-1:0];
            default: ;
         endcase
      end
   end

   // Register the incoming beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_weight_ff <= req_weight;
         in_parent_ff <= req_parent_output;
         in_random_ff <= req_random_sample;
         in_last_ff   <= req_last;
      end
   end

   ssn_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (in_valid_ff),
      .weight        (in_weight_ff),
      .parent_output (in_parent_ff),
      .random_sample (in_random_ff),
      .last          (in_last_ff),
      .sum_beat      (sum_beat)
   );

   ssn_sigmoid u_sigmoid (
      .sum            (sum_beat.sum),
      .random_sample  (sum_beat.random_sample),
      .high_threshold (high_threshold_ff),
      .low_threshold  (low_threshold_ff),
      .fire           (fire_in),
      .probability    (probability_in)
   );

   // Hold the result until the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sum_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && sum_beat.valid) begin
         rsp_fire_ff        <= fire_in;
         rsp_probability_ff <= probability_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fire        = rsp_fire_ff;
   assign rsp_probability = rsp_probability_ff;

endmodule

// ===== sv/ssn_checker.sv =====
// Port-level checker of the stochastic sigmoid neuron core, bound to the top level.
`include "stochastic_sigmoid_neuron_core_assert.svh"

module ssn_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_fire,
   input logic [15:0] rsp_probability,
   input logic        psel,
   input logic        penable,
   input logic        pwrite,
   input logic [2:0]  paddr,
   input logic [31:0] pwdata,
   input logic [31:0] prdata,
   input logic        pready
);

   // A stalled result beat keeps its payload
   `SSN_ASSERT_NEXT(rsp_hold_a, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fire) && $stable(rsp_probability))

   // No result beat right after reset
   `SSN_ASSERT_NOW(rsp_reset_a, $past(reset), !rsp_valid)

   // A written high threshold reads back in the next cycle
   `SSN_ASSERT_NOW(csr_readback_a, (psel && penable && pwrite && pready && paddr == 3'd0) ##1 (paddr == 3'd0 && !(psel && penable && pwrite)), prdata[15:0] == $past(pwdata[15:0]))

   // Unused read bits stay clear
   `SSN_ASSERT_NOW(csr_upper_a, pready, prdata[31:16] == 16'd0)

endmodule

bind stochastic_sigmoid_neuron_core ssn_checker u_ssn_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the stochastic sigmoid neuron core.
module tb_top;

   import ssn_pkg::*;

   // e^-1/16 in Q32, and the 40-bit accumulator limits
   localparam longint unsigned EXP_Q32 = 64'd4034748382;
   localparam longint SUM_HI = 64'sh7F_FFFF_FFFF;
   localparam longint SUM_LO = -64'sh80_0000_0000;
   localparam int STALL_LIMIT = 5000;
   localparam int RANDOM_BEATS_PER_PHASE = 100;

   typedef struct packed {
      logic        fire;
      logic [15:0] probability;
   } firing_t;

   typedef struct {
      int                 reps;
      logic signed [15:0] weight;
      logic [15:0]        parent;
      logic [15:0]        draw;
      bit                 is_last;
      bit                 typed;
      firing_t            want;
   } stim_row_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [15:0]   req_weight = '0;
   logic [15:0]          req_parent_output = '0;
   logic [15:0]          req_random_sample = '0;
   logic                 req_last = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_fire;
   logic [PROB_W-1:0]    rsp_probability;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                 pready;

   // expectation typed into the stimulus table, carried along with the beat
   bit                   beat_typed = 1'b0;
   firing_t              beat_want = '0;

   // predictor state
   logic [15:0]          logistic_lut [256];
   longint               membrane_sum = 0;
   logic [15:0]          thr_high = HIGH_THRESHOLD_RESET;
   logic [15:0]          thr_low = LOW_THRESHOLD_RESET;
   firing_t              predicted_firings [$];
   stim_row_t            stim_rows [$];

   int                   fault_count = 0;
   int                   stall_run = 0;
   int                   req_idle_pct = 0;
   int                   rsp_idle_pct = 0;
   int                   rsp_hold_left = 0;

   stochastic_sigmoid_neuron_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_weight        (req_weight),
      .req_parent_output (req_parent_output),
      .req_random_sample (req_random_sample),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fire          (rsp_fire),
      .rsp_probability   (rsp_probability),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Fill both halves of the logistic table in one sweep of the decaying exponent
   function automatic void build_logistic_lut();
      longint unsigned decay;
      longint unsigned den;
      longint unsigned pos;
      longint unsigned neg;
      decay = 64'd1 << 30;
      for (int k = 0; k <= 128; k++) begin
         den = (64'd1 << 30) + decay;
         pos = ((64'd1 << 46) + den / 2) / den;
         if (k < 128) begin
            logistic_lut[8'(128 + k)] = (pos > 64'd65535) ? 16'hFFFF : pos[15:0];
         end
         if (k > 0) begin
            neg = 64'd65536 - pos;
            logistic_lut[8'(128 - k)] = neg[15:0];
         end
         decay = (decay * EXP_Q32 + (64'd1 << 31)) >> 32;
      end
   endfunction

   // Accumulate one synapse; on the closing beat decide the firing and clear
   function automatic bit integrate_synapse(input logic signed [15:0] w,
         input logic [15:0] par, input logic [15:0] draw, input bit is_last,
         output firing_t res);
      longint acc;
      longint bucket;
      logic [15:0] prob;
      acc = membrane_sum + longint'(w) * longint'(par);
      if (acc > SUM_HI) begin
         acc = SUM_HI;
      end else if (acc < SUM_LO) begin
         acc = SUM_LO;
      end
      membrane_sum = acc;
      res = '0;
      if (!is_last) begin
         return 1'b0;
      end
      bucket = (acc >>> 23) + 128;
      if (bucket < 0) begin
         bucket = 0;
      end else if (bucket > 255) begin
         bucket = 255;
      end
      prob = logistic_lut[bucket[7:0]];
      if (prob > thr_high) begin
         res.fire = 1'b1;
      end else if (prob < thr_low) begin
         res.fire = 1'b0;
      end else begin
         res.fire = (draw <= prob);
      end
      res.probability = prob;
      membrane_sum = 0;
      return 1'b1;
   endfunction

   function automatic void add_row(input int reps, input int w, input int par,
         input int draw, input bit is_last, input bit typed, input bit fire,
         input int prob);
      stim_row_t r;
      r.reps = reps;
      r.weight = 16'(w);
      r.parent = 16'(par);
      r.draw = 16'(draw);
      r.is_last = is_last;
      r.typed = typed;
      r.want.fire = fire;
      r.want.probability = 16'(prob);
      stim_rows.insert(stim_rows.size(), r);
   endfunction

   // Watch both channels: predict on synapse beats, check result beats, guard stalls
   always @(posedge clock) begin
      firing_t got;
      firing_t want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (integrate_synapse(req_weight, req_parent_output, req_random_sample,
                  req_last, got)) begin
               predicted_firings.insert(predicted_firings.size(),
                  beat_typed ? beat_want : got);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_firings.size() == 0) begin
               $display("%0t: result with none expected: fire=%0b probability=%0d",
                  $time, rsp_fire, rsp_probability);
               fault_count++;
            end else begin
               want = predicted_firings.pop_front();
               if (rsp_fire !== want.fire) begin
                  $display("%0t: fire mismatch: expected %0b, actual %0b",
                     $time, want.fire, rsp_fire);
                  fault_count++;
               end
               if (rsp_probability !== want.probability) begin
                  $display("%0t: probability mismatch: expected %0d, actual %0d",
                     $time, want.probability, rsp_probability);
                  fault_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_run = 0;
         end else begin
            stall_run++;
         end
         if (stall_run >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   // Result side: hold off for a counted stretch when asked, else stall at random
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Offer one synapse beat after an optional gap and wait for its handshake
   task automatic send_beat(input logic signed [15:0] w, input logic [15:0] par,
         input logic [15:0] draw, input bit is_last, input bit typed,
         input firing_t want);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_weight <= w;
      req_parent_output <= par;
      req_random_sample <= draw;
      req_last <= is_last;
      beat_typed <= typed;
      beat_want <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid, wait out every pending result, then let the pipeline settle
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_firings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Write one register, then leave the bus idle
   task automatic csr_write(input csr_index_type idx, input logic [15:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {16'h0000, val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      if (idx == CSR_HIGH_THRESHOLD) begin
         thr_high = val;
      end else begin
         thr_low = val;
      end
      @(posedge clock);
   endtask

   // Read one register back and compare, then leave the bus idle
   task automatic csr_readback(input csr_index_type idx);
      logic [CSR_DATA_W-1:0] got;
      logic [15:0] want;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      want = (idx == CSR_HIGH_THRESHOLD) ? thr_high : thr_low;
      if (got[15:0] !== want) begin
         $display("%0t: register %s readback: expected %0d, actual %0d",
            $time, idx.name(), want, got[15:0]);
         fault_count++;
      end
      @(posedge clock);
   endtask

   // One random synapse set: mostly short sets of mixed magnitude, a few long
   // same-sign sets that drive the accumulator into saturation
   task automatic send_random_set(output int len);
      int style;
      bit neg;
      logic signed [15:0] w;
      logic [15:0] par;
      logic [15:0] draw;
      style = $urandom_range(99);
      neg = 1'($urandom_range(1));
      if (style < 2) begin
         len = $urandom_range(300, 256);
      end else if (style < 10) begin
         len = $urandom_range(24, 9);
      end else begin
         len = $urandom_range(8, 1);
      end
      for (int n = 0; n < len; n++) begin
         if (style < 2) begin
            w = neg ? 16'(16'h8000 + $urandom_range(255))
                    : 16'(16'h7FFF - $urandom_range(255));
            par = 16'(16'hFFFF - $urandom_range(511));
         end else begin
            case ($urandom_range(9)) inside
               [0:5]:   w = 16'($urandom_range(16383) - 8192);
               [6:8]:   w = 16'($urandom_range(65535));
               default: w = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            endcase
            case ($urandom_range(9)) inside
               [0:6]: par = 16'($urandom_range(32768));
               [7:8]: par = 16'($urandom_range(65535));
               default: begin
                  case ($urandom_range(2))
                     0: par = 16'h0000;
                     1: par = 16'h8000;
                     default: par = 16'hFFFF;
                  endcase
               end
            endcase
         end
         case ($urandom_range(9))
            0: draw = 16'h0000;
            1: draw = 16'hFFFF;
            default: draw = 16'($urandom_range(65535));
         endcase
         send_beat(w, par, draw, n == len - 1, 1'b0, '0);
      end
   endtask

   initial begin
      stim_row_t r;
      int sent;
      int len;
      logic [15:0] hi;
      logic [15:0] lo;
      build_logistic_lut();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_readback(CSR_HIGH_THRESHOLD);
      csr_readback(CSR_LOW_THRESHOLD);

      // zero sum sits at one half; sample at or below it fires
      add_row(1, 0, 0, 0, 1, 1, 1, 32768);
      add_row(1, 0, 0, 65535, 1, 1, 0, 32768);
      add_row(1, 0, 0, 32768, 1, 1, 1, 32768);
      add_row(1, 0, 0, 32769, 1, 1, 0, 32768);
      // far below the table and exactly at its lower edge
      add_row(1, -32768, 65535, 0, 1, 1, 0, 22);
      add_row(1, -32768, 32768, 0, 1, 1, 0, 22);
      // top of the table, just under and just past its upper edge
      add_row(1, 32767, 65535, 65535, 1, 0, 0, 0);
      add_row(1, 32767, 32768, 65535, 1, 0, 0, 0);
      add_row(2, 16384, 32768, 12345, 1, 0, 0, 0);
      // smallest negative sum rounds down one bucket
      add_row(1, -1, 1, 40000, 1, 0, 0, 0);
      // multi-synapse set closed by an empty synapse
      add_row(3, 4096, 32768, 0, 0, 0, 0, 0);
      add_row(1, 0, 0, 30000, 1, 0, 0, 0);
      // accumulator saturation past the synapse count, both signs
      add_row(300, 32767, 65535, 0, 1, 0, 0, 0);
      add_row(300, -32768, 65535, 0, 1, 1, 0, 22);
      // sum clears after a saturated set
      add_row(1, 0, 0, 0, 1, 1, 1, 32768);
      add_row(1, -32768, 0, 1, 1, 1, 1, 32768);
      add_row(1, 1, 65535, 32768, 0, 0, 0, 0);
      add_row(1, -1, 65535, 32768, 1, 1, 1, 32768);
      add_row(1, 2048, 16384, 50000, 1, 0, 0, 0);

      foreach (stim_rows[i]) begin
         r = stim_rows[i];
         for (int n = 0; n < r.reps; n++) begin
            send_beat(r.weight, r.parent, r.draw, r.is_last && (n == r.reps - 1),
               r.typed, r.want);
         end
      end

      // random phases under changing thresholds and idling
      for (int ph = 0; ph < 6; ph++) begin
         drain_pipeline();
         case (ph)
            0: begin hi = 16'hFFFF; lo = 16'h0000; end
            1: begin hi = 16'h0000; lo = 16'h0000; end
            2: begin hi = 16'hFFFF; lo = 16'hFFFF; end
            3: begin hi = 16'd100; lo = 16'd60000; end
            4: begin hi = 16'($urandom_range(65535)); lo = 16'($urandom_range(65535)); end
            default: begin hi = 16'd40000; lo = 16'd20000; end
         endcase
         csr_write(CSR_HIGH_THRESHOLD, hi);
         csr_write(CSR_LOW_THRESHOLD, lo);
         csr_readback(CSR_HIGH_THRESHOLD);
         csr_readback(CSR_LOW_THRESHOLD);
         if (ph < 2) begin
            req_idle_pct = 22;
            rsp_idle_pct = 59;
         end else if (ph < 4) begin
            req_idle_pct = 59;
            rsp_idle_pct = 22;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         // long result hold-off so the core backs up into its input
         if (ph == 1) begin
            rsp_hold_left = 400;
         end
         sent = 0;
         while (sent < RANDOM_BEATS_PER_PHASE) begin
            send_random_set(len);
            sent += len;
         end
      end
      drain_pipeline();

      if (fault_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
